### sv/cdgc_pkg.sv
package cdgc_pkg;

    localparam int unsigned MOD_BITS = 16;
    localparam int unsigned W = MOD_BITS;

    typedef struct packed {
        logic [W-1:0] point_x;
        logic [W-1:0] point_y;
        logic [W-1:0] coef_a;
    } t_req;

    typedef struct packed {
        logic [W-1:0] echo_x;
        logic [W-1:0] echo_y;
        logic [W-1:0] echo_a;
        logic [W-1:0] coef_b;
        logic [W-1:0] divisor;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_MUL,
        S_GCD,
        S_DONE
    } t_state;

endpackage

### sv/curve_discriminant_gcd_check_unit.sv
// Checks trial points (x, y, a) against modulus n: b = y^2 - x^3 - a*x mod n, then
// q = gcd(n, 4a^3 + 27b^2); a result is queued only when 1 < q < n. Requests enter
// a two-entry queue; one shared bit-serial divider does every reduction and every
// Euclid step, so a new request is taken only once the engine is idle again.
// Modulus below 2 gives no result.
module curve_discriminant_gcd_check_unit import cdgc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [W-1:0] i_cfg_data,
    input  logic         push,
    input  t_req         i_req,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output t_rsp         o_rsp
);
    logic [W-1:0] r_modulus;
    logic         w_qempty, w_take;
    t_req         w_qdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_modulus <= W'(45);
        else if (i_cfg_we) r_modulus <= i_cfg_data;
    end

    cdgc_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_data(i_req), .o_full(full),
        .i_pop(w_take), .o_empty(w_qempty), .o_data(w_qdata)
    );

    cdgc_engine u_eng (
        .i_clk, .i_rst_n, .i_modulus(r_modulus), .i_valid(!w_qempty),
        .i_req(w_qdata), .o_take(w_take), .o_empty(empty), .i_pop(pop), .o_rsp(o_rsp)
    );
endmodule

### sv/cdgc_fifo.sv
module cdgc_fifo import cdgc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_req o_data
);
    t_req       r_mem [2];
    logic [1:0] r_wp;
    logic [1:0] r_rp;

    assign o_full  = (r_wp[1] != r_rp[1]) && (r_wp[0] == r_rp[0]);
    assign o_empty = (r_wp == r_rp);
    assign o_data  = r_mem[r_rp[0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp[0]] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + 2'd1;
            end
        end
    end
endmodule

### sv/cdgc_engine.sv
module cdgc_engine import cdgc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_modulus,
    input  logic         i_valid,
    input  t_req         i_req,
    output logic         o_take,
    output logic         o_empty,
    input  logic         i_pop,
    output t_rsp         o_rsp
);
    // step program: 0-2 reduce x,y,a; then b and the discriminant terms mod n
    localparam int unsigned PW = 2 * W + 5;

    t_state       r_state, n_state;
    t_req         r_req;
    logic [W-1:0] r_n, r_xr, r_yr, r_ar, r_t, r_b, r_u, r_v;
    logic [3:0]   r_step;
    logic [PW-1:0] r_rem;
    logic [W-1:0]  r_den;
    logic [5:0]    r_cnt;
    logic          r_div_busy;
    logic          r_full;
    t_rsp          r_rsp;
    logic [PW-1:0] w_num;
    logic [PW:0]   w_trial;

    assign o_empty = !r_full;
    assign o_rsp   = r_rsp;
    assign o_take  = (r_state == S_IDLE) && i_valid;

    // restoring divider: remainder of r_rem by r_den, one bit per cycle
    assign w_trial = {1'b0, r_rem} - ({{(PW+1-W){1'b0}}, r_den} << r_cnt);

    always_comb begin
        unique case (r_step)
            4'd0:    w_num = PW'(r_req.point_x);
            4'd1:    w_num = PW'(r_req.point_y);
            4'd2:    w_num = PW'(r_req.coef_a);
            4'd3:    w_num = PW'(r_yr) * PW'(r_yr);
            4'd4:    w_num = PW'(r_xr) * PW'(r_xr);
            4'd5:    w_num = PW'(r_t) * PW'(r_xr);
            4'd6:    w_num = PW'(r_ar) * PW'(r_xr) + PW'(r_t);
            4'd7:    w_num = PW'(r_u) + PW'(r_n) - PW'(r_t);
            4'd8:    w_num = PW'(r_ar) * PW'(r_ar);
            4'd9:    w_num = PW'(r_t) * PW'(r_ar);
            4'd10:   w_num = PW'(r_b) * PW'(r_b);
            4'd11:   w_num = PW'(r_t) * PW'(27) + PW'(r_u) * PW'(4);
            default: w_num = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = (i_modulus < W'(2)) ? S_IDLE : S_MOD;
            S_MOD:  if (!r_div_busy && r_step == 4'd12) n_state = S_GCD;
            S_MUL:  n_state = S_MOD;
            S_GCD:  if (!r_div_busy && r_v == '0) n_state = S_DONE;
            S_DONE: if (!r_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full  <= 1'b0;
            r_div_busy <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_pop && r_full) r_full <= 1'b0;
            if (r_state == S_IDLE && i_valid) begin
                r_req <= i_req;
                r_n   <= i_modulus;
                r_step <= '0;
                r_div_busy <= 1'b0;
                r_cnt <= '0;
            end
            if (r_state == S_MOD) begin
                if (!r_div_busy) begin
                    if (r_cnt == '0 && r_step < 4'd12) begin
                        r_rem <= w_num;
                        r_den <= r_n;
                        r_cnt <= 6'(PW - W);
                        r_div_busy <= 1'b1;
                    end
                end else begin
                    if (!w_trial[PW]) r_rem <= w_trial[PW-1:0];
                    if (r_cnt == '0) begin
                        r_div_busy <= 1'b0;
                        r_step <= r_step + 4'd1;
                        unique case (r_step)
                            4'd0: r_xr <= (w_trial[PW] ? r_rem[W-1:0] : w_trial[W-1:0]);
                            4'd1: r_yr <= (w_trial[PW] ? r_rem[W-1:0] : w_trial[W-1:0]);
                            4'd2: r_ar <= (w_trial[PW] ? r_rem[W-1:0] : w_trial[W-1:0]);
                            4'd3: r_u  <= (w_trial[PW] ? r_rem[W-1:0] : w_trial[W-1:0]);
                            4'd4, 4'd5, 4'd6, 4'd8, 4'd9:
                                r_t <= (w_trial[PW] ? r_rem[W-1:0] : w_trial[W-1:0]);
                            4'd7: begin
                                r_b <= (w_trial[PW] ? r_rem[W-1:0] : w_trial[W-1:0]);
                                r_u <= r_t;
                            end
                            4'd10: begin
                                r_t <= (w_trial[PW] ? r_rem[W-1:0] : w_trial[W-1:0]);
                                r_u <= r_t;
                            end
                            4'd11: begin
                                r_v <= (w_trial[PW] ? r_rem[W-1:0] : w_trial[W-1:0]);
                                r_u <= r_n;
                            end
                            default: r_t <= r_t;
                        endcase
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
            end
            // euclid: u mod v through the same divider
            if (r_state == S_GCD) begin
                if (!r_div_busy) begin
                    if (r_v != '0) begin
                        r_rem <= PW'(r_u);
                        r_den <= r_v;
                        r_cnt <= 6'(W - 1);
                        r_div_busy <= 1'b1;
                    end
                end else begin
                    if (!w_trial[PW]) r_rem <= w_trial[PW-1:0];
                    if (r_cnt == '0) begin
                        r_div_busy <= 1'b0;
                        r_u <= r_v;
                        r_v <= (w_trial[PW] ? r_rem[W-1:0] : w_trial[W-1:0]);
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
            end
            if (r_state == S_DONE && !r_full) begin
                if (r_u > W'(1) && r_u < r_n) begin
                    r_full <= 1'b1;
                    r_rsp  <= '{echo_x: r_req.point_x, echo_y: r_req.point_y,
                                echo_a: r_req.coef_a, coef_b: r_b, divisor: r_u};
                end
            end
        end
    end
endmodule
